[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under the synchronous active-low reset.
`define PIC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pic assertion failed");

// Next-cycle implication under the synchronous active-low reset.
`define PIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pic assertion failed");

`endif

[rtl/pic_pkg.sv]
// Types and constants shared by the interrupt controller modules.
`default_nettype none

package pic_pkg;

  localparam int IRQ_W  = 6;
  localparam int VAL_W  = 9;
  localparam int PRIO_W = 8;

  localparam logic [IRQ_W-1:0] HARD_LINE_RST = 6'd63;
  localparam logic [VAL_W-1:0] RUN_PRIO_RST  = 9'd256;

  typedef enum logic [3:0] {
    ACT_SET       = 4'd0,
    ACT_RAISE_NOW = 4'd1,
    ACT_RAISE_SW  = 4'd2,
    ACT_CLEAR     = 4'd3,
    ACT_ENABLE    = 4'd4,
    ACT_DISABLE   = 4'd5,
    ACT_SET_PRIO  = 4'd6,
    ACT_READ_PRIO = 4'd7,
    ACT_READ_EN   = 4'd8,
    ACT_SET_RUN   = 4'd9,
    ACT_LOCK      = 4'd10,
    ACT_CLR_EN    = 4'd11,
    ACT_CLR_ALL   = 4'd12
  } act_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_SEED,
    S_SCAN,
    S_FIN
  } state_t;

  // Action broadcast to every line cell.
  typedef struct packed {
    logic              vld;
    act_t              act;
    logic [IRQ_W-1:0]  irq;
    logic [PRIO_W-1:0] prio;
  } cmd_t;

  // Per-line state reported back to the controller.
  typedef struct packed {
    logic              raw;
    logic              en;
    logic              mp;
    logic [PRIO_W-1:0] prio;
  } line_stat_t;

  // Search token that walks down the cell chain.
  typedef struct packed {
    logic             tok;
    logic             vld;
    logic [IRQ_W-1:0] idx;
    logic [VAL_W-1:0] lim;
  } scan_t;

endpackage

`default_nettype wire

[rtl/pic_cell.sv]
// One interrupt line: pending, enable and priority state plus one search step.
`default_nettype none

module pic_cell #(
  parameter int IDX       = 0,
  parameter int PRIO_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pic_pkg::cmd_t      cmd,
  input  wire pic_pkg::scan_t     scan_in,
  output pic_pkg::scan_t          scan_out,
  output pic_pkg::line_stat_t     stat
);
  import pic_pkg::*;

  logic                 raw_r, raw_nxt;
  logic                 en_r, en_nxt;
  logic                 mp_r, mp_nxt;
  logic [PRIO_BITS-1:0] prio_r, prio_nxt;
  scan_t                scan_r, scan_nxt;
  logic                 hit;
  logic                 take;

  assign hit = cmd.vld && (cmd.irq == IRQ_W'(IDX));

  always_comb begin
    raw_nxt  = raw_r;
    en_nxt   = en_r;
    mp_nxt   = mp_r;
    prio_nxt = prio_r;
    if (cmd.vld) begin
      unique case (cmd.act)
        ACT_SET, ACT_RAISE_NOW, ACT_RAISE_SW: begin
          if (hit) begin
            raw_nxt = 1'b1;
            if (en_r) mp_nxt = 1'b1;
          end
        end
        ACT_CLEAR: begin
          if (hit) begin
            raw_nxt = 1'b0;
            mp_nxt  = 1'b0;
          end
        end
        ACT_ENABLE: begin
          if (hit) begin
            en_nxt = 1'b1;
            if (raw_r) mp_nxt = 1'b1;
          end
        end
        ACT_DISABLE: begin
          if (hit) en_nxt = 1'b0;
        end
        ACT_SET_PRIO: begin
          if (hit) prio_nxt = cmd.prio[PRIO_BITS-1:0];
        end
        ACT_CLR_EN: begin
          mp_nxt = 1'b0;
          if (en_r) raw_nxt = 1'b0;
        end
        ACT_CLR_ALL: begin
          mp_nxt  = 1'b0;
          raw_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Strict compare keeps the earlier (lower index) line on a tie.
  assign take = scan_in.tok && mp_r && (VAL_W'(prio_r) < scan_in.lim);

  always_comb begin
    scan_nxt = scan_in;
    if (take) begin
      scan_nxt.vld = 1'b1;
      scan_nxt.idx = IRQ_W'(IDX);
      scan_nxt.lim = VAL_W'(prio_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r  <= 1'b0;
      en_r   <= 1'b0;
      mp_r   <= 1'b0;
      prio_r <= '1;
      scan_r <= '0;
    end else begin
      raw_r  <= raw_nxt;
      en_r   <= en_nxt;
      mp_r   <= mp_nxt;
      prio_r <= prio_nxt;
      scan_r <= scan_nxt;
    end
  end

  assign scan_out  = scan_r;
  assign stat.raw  = raw_r;
  assign stat.en   = en_r;
  assign stat.mp   = mp_r;
  assign stat.prio = PRIO_W'(prio_r);

endmodule

`default_nettype wire

[rtl/priority_interrupt_controller.sv]
// Items are taken one at a time: a new item enters only after the previous one's result
// is in the output register. The winner search token visits one line cell per cycle,
// so the length of the cell chain and output stalls set how long each item takes.
// The output register lets a new item enter while the previous result waits.
// Synchronous active-low reset clears all lines, unlocks, sets the running priority
// to 256 and the hard line to 63; no clearing pass is needed after reset.
`default_nettype none

module priority_interrupt_controller #(
  parameter int NUM_LINES = 64,
  parameter int PRIO_BITS = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // Configuration: hard line whose raises override the lock.
  input  wire logic                      cfg_wr_en,
  input  wire logic [pic_pkg::IRQ_W-1:0] cfg_wr_data,
  // Action item.
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [3:0]                in_action,
  input  wire logic [pic_pkg::IRQ_W-1:0] in_irq,
  input  wire logic [pic_pkg::VAL_W-1:0] in_value,
  // Result item.
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_winner_valid,
  output logic [pic_pkg::IRQ_W-1:0]      out_winner_irq,
  output logic                           out_wake_cpu,
  output logic [7:0]                     out_read_data,
  output logic                           out_locked,
  output logic                           out_range_error
);
  import pic_pkg::*;

  // Control flow: IDLE takes an item, APPLY updates every cell and the global
  // registers at once, SEED launches the search token into the first cell,
  // SCAN waits for it to leave the last cell, FIN loads the output register.
  state_t state_r, state_nxt;

  // Registered item.
  act_t             act_r;
  logic [IRQ_W-1:0] irq_r;
  logic [VAL_W-1:0] value_r;

  // Global controller state.
  logic [IRQ_W-1:0] hard_r;
  logic             lock_r, lock_nxt;
  logic             ov_r, ov_nxt;
  logic [VAL_W-1:0] run_r, run_nxt;

  // Per-item side results, captured in APPLY and held until FIN.
  logic             wake_r, wake_nxt;
  logic [7:0]       rdata_r, rdata_nxt;
  logic             rerr_r, rerr_nxt;

  // Winner taken from the last cell as the token leaves the chain.
  logic             win_vld_r;
  logic [IRQ_W-1:0] win_idx_r;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  logic             ow_valid_r;
  logic [IRQ_W-1:0] ow_irq_r;
  logic             ow_wake_r;
  logic [7:0]       ow_rdata_r;
  logic             ow_locked_r;
  logic             ow_rerr_r;

  logic       accept;
  logic       load_out;
  logic       seed;
  logic       rerr;
  logic       hard_hit;
  logic       any_mp;
  line_stat_t sel;
  cmd_t       cmd;

  line_stat_t stat_w [NUM_LINES];
  scan_t      scan_w [NUM_LINES+1];

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    seed      = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        state_nxt = S_SEED;
      end
      S_SEED: begin
        seed      = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_w[NUM_LINES].tok) state_nxt = S_FIN;
      end
      S_FIN: begin
        // The winner waits in its own register until the output register is free.
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= act_t'(in_action);
      irq_r   <= in_irq;
      value_r <= in_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Addressed line lookup and the any-pending summary (state before the action)
  // ---------------------------------------------------------------------------
  always_comb begin
    sel    = '0;
    any_mp = 1'b0;
    for (int i = 0; i < NUM_LINES; i++) begin
      if (irq_r == IRQ_W'(i)) sel = stat_w[i];
      any_mp = any_mp | stat_w[i].mp;
    end
  end

  // Per-line actions on a line beyond the last one are rejected.
  assign rerr     = (act_r <= ACT_READ_EN) && ({1'b0, irq_r} >= (IRQ_W+1)'(NUM_LINES));
  assign hard_hit = (irq_r == hard_r);

  // ---------------------------------------------------------------------------
  // Global state update and side results
  // ---------------------------------------------------------------------------
  always_comb begin
    lock_nxt  = lock_r;
    ov_nxt    = ov_r;
    run_nxt   = run_r;
    wake_nxt  = wake_r;
    rdata_nxt = rdata_r;
    rerr_nxt  = rerr_r;
    if (state_r == S_APPLY) begin
      wake_nxt  = 1'b0;
      rdata_nxt = '0;
      rerr_nxt  = rerr;
      if (!rerr) begin
        unique case (act_r)
          ACT_SET, ACT_RAISE_NOW: begin
            // Hard line raises, and raises with override armed, wake even while locked.
            if (!lock_r || ov_r || hard_hit) begin
              ov_nxt   = 1'b0;
              wake_nxt = 1'b1;
            end
          end
          ACT_RAISE_SW: begin
            if (hard_hit) ov_nxt = 1'b1;
            wake_nxt = !lock_r;
          end
          ACT_ENABLE: begin
            // Enabling a line that is already raw pending raises it again.
            if (sel.raw) begin
              if (hard_hit) ov_nxt = 1'b1;
              wake_nxt = !lock_r;
            end
          end
          ACT_READ_PRIO: begin
            rdata_nxt = sel.prio;
          end
          ACT_READ_EN: begin
            rdata_nxt = {7'd0, sel.en};
          end
          ACT_SET_RUN: begin
            run_nxt = value_r;
          end
          ACT_LOCK: begin
            lock_nxt  = (value_r != '0);
            rdata_nxt = {7'd0, lock_r};
            // Unlocking with something pending wakes the CPU.
            wake_nxt  = lock_r && (value_r == '0) && any_mp;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hard_r <= HARD_LINE_RST;
      lock_r <= 1'b0;
      ov_r   <= 1'b0;
      run_r  <= RUN_PRIO_RST;
    end else begin
      if (cfg_wr_en) hard_r <= cfg_wr_data;
      lock_r <= lock_nxt;
      ov_r   <= ov_nxt;
      run_r  <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wake_r  <= wake_nxt;
    rdata_r <= rdata_nxt;
    rerr_r  <= rerr_nxt;
  end

  // ---------------------------------------------------------------------------
  // Cell chain: the action is broadcast to all cells in APPLY, then a search
  // token seeded with the running priority walks from line 0 upward.
  // ---------------------------------------------------------------------------
  assign cmd.vld  = (state_r == S_APPLY) && !rerr;
  assign cmd.act  = act_r;
  assign cmd.irq  = irq_r;
  assign cmd.prio = value_r[PRIO_W-1:0];

  assign scan_w[0].tok = seed;
  assign scan_w[0].vld = 1'b0;
  assign scan_w[0].idx = '0;
  assign scan_w[0].lim = run_r;

  for (genvar g = 0; g < NUM_LINES; g++) begin : g_line
    pic_cell #(
      .IDX       (g),
      .PRIO_BITS (PRIO_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .scan_in  (scan_w[g]),
      .scan_out (scan_w[g+1]),
      .stat     (stat_w[g])
    );
  end

  // The token is in the last cell for a single cycle only, so its result is
  // kept here until the output register takes it.
  always_ff @(posedge clk) begin
    if (state_r == S_SCAN && scan_w[NUM_LINES].tok) begin
      win_vld_r <= scan_w[NUM_LINES].vld;
      win_idx_r <= scan_w[NUM_LINES].idx;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // No winner is reported while the controller is locked.
  always_ff @(posedge clk) begin
    if (load_out) begin
      ow_valid_r  <= win_vld_r && !lock_r;
      ow_irq_r    <= (win_vld_r && !lock_r) ? win_idx_r : '0;
      ow_wake_r   <= wake_r;
      ow_rdata_r  <= rdata_r;
      ow_locked_r <= lock_r;
      ow_rerr_r   <= rerr_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_winner_valid = ow_valid_r;
  assign out_winner_irq   = ow_irq_r;
  assign out_wake_cpu     = ow_wake_r;
  assign out_read_data    = ow_rdata_r;
  assign out_locked       = ow_locked_r;
  assign out_range_error  = ow_rerr_r;

endmodule

`default_nettype wire

[rtl/pic_checker.sv]
// Port-level checks on the interrupt controller result channel, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module pic_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic                      out_winner_valid,
  input wire logic [pic_pkg::IRQ_W-1:0] out_winner_irq,
  input wire logic                      out_wake_cpu,
  input wire logic [7:0]                out_read_data,
  input wire logic                      out_locked,
  input wire logic                      out_range_error
);

  `PIC_ASSERT_NOW(a_no_winner_when_locked, clk, rst_n, out_valid && out_winner_valid, !out_locked)

  `PIC_ASSERT_NOW(a_idle_winner_zero, clk, rst_n, out_valid && !out_winner_valid, out_winner_irq == '0)

  `PIC_ASSERT_NOW(a_rejected_item_quiet, clk, rst_n, out_valid && out_range_error, !out_wake_cpu && (out_read_data == '0))

  `PIC_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_winner_irq))

endmodule

bind priority_interrupt_controller pic_checker u_pic_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_winner_valid (out_winner_valid),
  .out_winner_irq   (out_winner_irq),
  .out_wake_cpu     (out_wake_cpu),
  .out_read_data    (out_read_data),
  .out_locked       (out_locked),
  .out_range_error  (out_range_error)
);

`default_nettype wire

[sim/pic_result_checker.sv]
// Scoreboard for the interrupt controller: tracks register state, predicts and checks results.
module pic_result_checker #(
  parameter int NUM_LINES = 64,
  parameter int PRIO_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [pic_pkg::IRQ_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [3:0]                 in_action,
  input  logic [pic_pkg::IRQ_W-1:0]  in_irq,
  input  logic [pic_pkg::VAL_W-1:0]  in_value,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       out_winner_valid,
  input  logic [pic_pkg::IRQ_W-1:0]  out_winner_irq,
  input  logic                       out_wake_cpu,
  input  logic [7:0]                 out_read_data,
  input  logic                       out_locked,
  input  logic                       out_range_error,
  output int                         fail_count,
  output int                         pending_count
);

  timeunit 1ns;
  timeprecision 1ps;

  import pic_pkg::*;

  localparam logic [VAL_W-1:0] PRIO_MASK = VAL_W'((1 << PRIO_BITS) - 1);

  typedef struct packed {
    logic             win_vld;
    logic [IRQ_W-1:0] win_irq;
    logic             wake;
    logic [7:0]       rdata;
    logic             locked;
    logic             rerr;
  } pic_result_t;

  // Shadow copy of the controller's registers.
  logic [63:0]       raw_pend;
  logic [63:0]       mask_pend;
  logic [63:0]       line_en;
  logic [PRIO_W-1:0] line_prio [64];
  logic              lock_q;
  logic              override_q;
  logic [VAL_W-1:0]  run_prio;
  logic [IRQ_W-1:0]  hard_line;

  pic_result_t expected_results[$];
  int mismatches = 0;
  int waiting = 0;

  assign fail_count    = mismatches;
  assign pending_count = waiting;

  function automatic void raise_line(input logic [IRQ_W-1:0] line);
    if (line == hard_line) override_q = 1'b1;
    raw_pend[line] = 1'b1;
    if (line_en[line]) mask_pend[line] = 1'b1;
  endfunction

  function automatic pic_result_t apply_action(input logic [3:0] act,
                                               input logic [IRQ_W-1:0] line,
                                               input logic [VAL_W-1:0] value);
    pic_result_t res;
    logic prev_lock;
    int best;
    res = '0;
    best = 256;
    if (act <= ACT_READ_EN && int'(line) >= NUM_LINES) begin
      res.rerr = 1'b1;
    end else begin
      case (act)
        ACT_SET, ACT_RAISE_NOW: begin
          raise_line(line);
          if (!lock_q || override_q) begin
            override_q = 1'b0;
            res.wake = 1'b1;
          end
        end
        ACT_RAISE_SW: begin
          raise_line(line);
          if (!lock_q) res.wake = 1'b1;
        end
        ACT_CLEAR: begin
          raw_pend[line]  = 1'b0;
          mask_pend[line] = 1'b0;
        end
        ACT_ENABLE: begin
          line_en[line] = 1'b1;
          // An enable of a line that is already raw pending raises it again.
          if (raw_pend[line]) begin
            raise_line(line);
            if (!lock_q) res.wake = 1'b1;
          end
        end
        ACT_DISABLE:   line_en[line] = 1'b0;
        ACT_SET_PRIO:  line_prio[line] = PRIO_W'(value & PRIO_MASK);
        ACT_READ_PRIO: res.rdata = 8'(line_prio[line]);
        ACT_READ_EN:   res.rdata = {7'd0, line_en[line]};
        ACT_SET_RUN:   run_prio = value;
        ACT_LOCK: begin
          prev_lock = lock_q;
          lock_q = (value != '0);
          res.rdata = {7'd0, prev_lock};
          if (prev_lock && !lock_q && mask_pend != '0) res.wake = 1'b1;
        end
        ACT_CLR_EN: begin
          mask_pend = '0;
          raw_pend  = raw_pend & ~line_en;
        end
        ACT_CLR_ALL: begin
          mask_pend = '0;
          raw_pend  = '0;
        end
        default: ;
      endcase
    end
    if (!lock_q) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        if (mask_pend[i] && int'(line_prio[i]) < best &&
            int'(line_prio[i]) < int'(run_prio)) begin
          best = int'(line_prio[i]);
          res.win_irq = IRQ_W'(i);
          res.win_vld = 1'b1;
        end
      end
    end
    res.locked = lock_q;
    return res;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    pic_result_t want;
    if (!rst_n) begin
      raw_pend   = '0;
      mask_pend  = '0;
      line_en    = '0;
      for (int i = 0; i < 64; i++) line_prio[i] = PRIO_W'(PRIO_MASK);
      lock_q     = 1'b0;
      override_q = 1'b0;
      run_prio   = RUN_PRIO_RST;
      hard_line  = HARD_LINE_RST;
      expected_results.delete();
    end else begin
      if (cfg_wr_en) hard_line = cfg_wr_data;
      // A result leaves after its item has entered, so check before predicting.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual winner %0d/%0d wake %0d",
                   $time, out_winner_valid, out_winner_irq, out_wake_cpu);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("winner_valid", want.win_vld, out_winner_valid);
          check_field("winner_irq", want.win_irq, out_winner_irq);
          check_field("wake_cpu", want.wake, out_wake_cpu);
          check_field("read_data", want.rdata, out_read_data);
          check_field("locked", want.locked, out_locked);
          check_field("range_error", want.rerr, out_range_error);
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(apply_action(in_action, in_irq, in_value));
    end
    waiting <= expected_results.size();
  end

endmodule

[sim/priority_interrupt_controller_tb.sv]
// Testbench top for the interrupt controller: clock, reset, stimulus and verdict.
module priority_interrupt_controller_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import pic_pkg::*;

  localparam int NUM_LINES = 64;
  localparam int PRIO_BITS = 8;
  // Codes above the last defined action; the block must treat them as no-ops.
  localparam logic [3:0] ACT_UNUSED_LO = 4'd13;
  localparam logic [3:0] ACT_UNUSED_HI = 4'd15;
  localparam int ITEMS_PER_PHASE = 290;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             cfg_wr_en = 1'b0;
  logic [IRQ_W-1:0] cfg_wr_data = '0;

  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [3:0]       in_action = '0;
  logic [IRQ_W-1:0] in_irq = '0;
  logic [VAL_W-1:0] in_value = '0;

  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_winner_valid;
  logic [IRQ_W-1:0] out_winner_irq;
  logic             out_wake_cpu;
  logic [7:0]       out_read_data;
  logic             out_locked;
  logic             out_range_error;

  int fail_count;
  int pending_count;

  // The hard line currently programmed, so that random items can aim at it.
  logic [IRQ_W-1:0] hard_line_now = HARD_LINE_RST;

  always #5 clk = ~clk;

  priority_interrupt_controller #(
    .NUM_LINES(NUM_LINES),
    .PRIO_BITS(PRIO_BITS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_irq          (in_irq),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_winner_valid(out_winner_valid),
    .out_winner_irq  (out_winner_irq),
    .out_wake_cpu    (out_wake_cpu),
    .out_read_data   (out_read_data),
    .out_locked      (out_locked),
    .out_range_error (out_range_error)
  );

  pic_result_checker #(
    .NUM_LINES(NUM_LINES),
    .PRIO_BITS(PRIO_BITS)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_irq          (in_irq),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_winner_valid(out_winner_valid),
    .out_winner_irq  (out_winner_irq),
    .out_wake_cpu    (out_wake_cpu),
    .out_read_data   (out_read_data),
    .out_locked      (out_locked),
    .out_range_error (out_range_error),
    .fail_count      (fail_count),
    .pending_count   (pending_count)
  );

  // The receiver switches between modes of its own: always ready, ready at
  // random, and mostly stalled. Each mode lasts a random stretch of cycles so
  // that stalls land on every part of the block's scan.
  int ready_mode = 0;
  int mode_left = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 11) == 0);
    endcase
  end

  // Presents one item and holds it until the block takes it. The valid stays
  // high on return; the caller lowers it when a burst ends.
  task automatic send_item(input logic [3:0] act, input logic [IRQ_W-1:0] line,
                           input logic [VAL_W-1:0] value);
    in_valid  <= 1'b1;
    in_action <= act;
    in_irq    <= line;
    in_value  <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Builds one random action. Lines are often drawn from a small group and
  // from the hard line so that raise, enable and clear actions interact, and
  // priorities are often small so that ties between lines are common.
  task automatic send_random_item();
    int pick;
    logic [3:0] act;
    logic [IRQ_W-1:0] line;
    logic [VAL_W-1:0] value;
    pick = $urandom_range(0, 99);
    if (pick < 30) line = IRQ_W'($urandom_range(0, 3));
    else if (pick < 45) line = hard_line_now;
    else line = IRQ_W'($urandom_range(0, 63));
    value = VAL_W'($urandom_range(0, 511));
    pick = $urandom_range(0, 99);
    if (pick < 11) act = ACT_SET;
    else if (pick < 22) act = ACT_RAISE_NOW;
    else if (pick < 32) act = ACT_RAISE_SW;
    else if (pick < 38) act = ACT_CLEAR;
    else if (pick < 50) act = ACT_ENABLE;
    else if (pick < 56) act = ACT_DISABLE;
    else if (pick < 68) act = ACT_SET_PRIO;
    else if (pick < 72) act = ACT_READ_PRIO;
    else if (pick < 76) act = ACT_READ_EN;
    else if (pick < 82) act = ACT_SET_RUN;
    else if (pick < 92) act = ACT_LOCK;
    else if (pick < 95) act = ACT_CLR_EN;
    else if (pick < 98) act = ACT_CLR_ALL;
    else act = 4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    pick = $urandom_range(0, 99);
    case (act)
      ACT_SET_PRIO: if (pick < 50) value = VAL_W'($urandom_range(0, 7));
      ACT_SET_RUN: begin
        if (pick < 30) value = RUN_PRIO_RST;
        else if (pick < 45) value = VAL_W'($urandom_range(0, 8));
      end
      ACT_LOCK: begin
        if (pick < 45) value = '0;
        else if (pick < 80) value = VAL_W'(1);
      end
      default: ;
    endcase
    send_item(act, line, value);
  endtask

  // Random items in bursts. A zero gap keeps the valid high into the next
  // burst; otherwise the valid drops for a random number of cycles, sometimes
  // longer than a whole scan of the line chain.
  task automatic run_random(input int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) begin
        send_random_item();
        left--;
      end
      gap = $urandom_range(0, 99);
      if (gap < 30) gap = 0;
      else if (gap < 80) gap = $urandom_range(1, 8);
      else gap = $urandom_range(9, 90);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  // The hard line is only reprogrammed while the block is idle: a full scan
  // time has passed and every expected result has come back.
  task automatic write_hard_line(input logic [IRQ_W-1:0] line);
    repeat (NUM_LINES + 8) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    cfg_wr_en     <= 1'b1;
    cfg_wr_data   <= line;
    hard_line_now = line;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk with the hard line at its reset value of 63.
    send_item(ACT_READ_PRIO, 6'd0, 9'd0);        // reset priority reads as all ones
    send_item(ACT_READ_EN, 6'd63, 9'd511);
    send_item(ACT_SET_PRIO, 6'd63, 9'd0);
    send_item(ACT_SET_PRIO, 6'd0, 9'd511);       // only the low priority bits are kept
    send_item(ACT_READ_PRIO, 6'd0, 9'd0);
    send_item(ACT_ENABLE, 6'd63, 9'd0);
    send_item(ACT_SET, 6'd63, 9'd0);             // unlocked raise wakes and wins
    send_item(ACT_READ_EN, 6'd63, 9'd0);
    send_item(ACT_LOCK, 6'd0, 9'd1);             // lock hides the winner
    send_item(ACT_RAISE_SW, 6'd10, 9'd0);        // raw pending only, line not enabled
    send_item(ACT_ENABLE, 6'd10, 9'd0);          // enable re-raises, no wake while locked
    send_item(ACT_RAISE_NOW, 6'd20, 9'd0);       // locked, no override: no wake
    send_item(ACT_RAISE_NOW, 6'd63, 9'd0);       // hard line breaks through the lock once
    send_item(ACT_RAISE_SW, 6'd63, 9'd0);        // arms the override without waking
    send_item(ACT_SET, 6'd1, 9'd0);              // spends the armed override
    send_item(ACT_LOCK, 6'd0, 9'd0);             // unlock with lines pending wakes
    send_item(ACT_SET_PRIO, 6'd10, 9'd256);      // ties with line 63, lower index wins
    send_item(ACT_SET_RUN, 6'd0, 9'd0);          // nothing beats running priority zero
    send_item(ACT_SET_RUN, 6'd0, 9'd511);
    send_item(ACT_DISABLE, 6'd10, 9'd0);         // masked pending survives a disable
    send_item(ACT_CLEAR, 6'd10, 9'd0);
    send_item(ACT_CLR_EN, 6'd0, 9'd0);
    send_item(ACT_ENABLE, 6'd20, 9'd0);          // raw pending line raised by enable
    send_item(ACT_CLR_ALL, 6'd0, 9'd0);
    send_item(ACT_LOCK, 6'd0, 9'd256);
    send_item(ACT_LOCK, 6'd0, 9'd0);             // unlock with nothing pending: no wake
    send_item(ACT_UNUSED_LO, 6'd63, 9'd511);
    send_item(ACT_UNUSED_HI, 6'd0, 9'd0);
    in_valid <= 1'b0;

    // Random phases under different hard lines, both extremes included.
    write_hard_line(6'd0);
    run_random(ITEMS_PER_PHASE);
    write_hard_line(IRQ_W'($urandom_range(1, 62)));
    run_random(ITEMS_PER_PHASE);
    write_hard_line(6'd63);
    run_random(ITEMS_PER_PHASE);
    write_hard_line(IRQ_W'($urandom_range(0, 63)));
    run_random(ITEMS_PER_PHASE);

    repeat (NUM_LINES + 8) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    if (fail_count == 0) begin
      $display("** priority_interrupt_controller: PASSED **");
    end else begin
      $display("** priority_interrupt_controller: FAILED **");
    end
    $finish;
  end

  // Watchdog: ten times the slowest expected run.
  initial begin
    #10_000_000;
    $display("** priority_interrupt_controller: FAILED **");
    $finish;
  end

endmodule

[priority_interrupt_controller.f]
+incdir+rtl
rtl/pic_pkg.sv
rtl/pic_cell.sv
rtl/priority_interrupt_controller.sv
rtl/pic_checker.sv
sim/pic_result_checker.sv
sim/priority_interrupt_controller_tb.sv
